### hdl/multi_channel_countdown_timer_macros.svh
// assertion macros for the countdown timer bank
// used by the top level only, no other dependencies
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MCT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define MCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/mctmr_pkg.sv
// shared types and constants of the countdown timer bank
// no dependencies
`timescale 1ns / 1ps

package mctmr_pkg;

	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_RESUME = 3'd2;
	localparam logic [2:0] MODE_RESET  = 3'd3;
	localparam logic [2:0] MODE_QUERY  = 3'd4;
	localparam logic [2:0] MODE_ALLOC  = 3'd5;

	localparam int MAX_RESULTS = 32;
	localparam int EVT_CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [2:0]  mode;
		logic [4:0]  timer_id;
		logic [31:0] period_ticks;
		logic        periodic;
		logic        notify;
	} req_t;

	typedef struct packed {
		logic       event_valid;
		logic [4:0] event_timer;
		logic       count_zero;
		logic       paused;
		logic [4:0] new_id;
		logic       id_valid;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic rd_req;
		logic exec;
		logic scan;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic req_tick;
		logic scan_done;
		logic can_push;
	} sts_t;

endpackage

### hdl/multi_channel_countdown_timer.sv
// Bank of NUM_TIMERS countdown timers with a request/response interface. A tick walks
// timers 0 up to the allocated count, one timer per cycle unless stalled, through the
// count memory (registered read, then update and write back), and returns one response
// per notifying expiry, up to MAX_RESULTS of them, or one empty response. Every other
// request reads, executes and pushes one response. Responses that are not taken stall the walk.
// Top level: controller, datapath; depends on mctmr_pkg and the macros header
`timescale 1ns / 1ps
`include "multi_channel_countdown_timer_macros.svh"

module multi_channel_countdown_timer #(
	parameter int NUM_TIMERS  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mctmr_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mctmr_pkg::rsp_t rsp
);

	mctmr_pkg::cmd_t cmd;
	mctmr_pkg::sts_t sts;

	mctmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mctmr_dp #(
		.NUM_TIMERS (NUM_TIMERS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	`MCT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`MCT_ASSERT(a_event_fields_clean, clk, arst_n,
		!(rsp_valid && rsp.event_valid) || (!rsp.id_valid && !rsp.count_zero && !rsp.paused))
	`MCT_ASSERT_NEXT(a_final_then_idle, clk, arst_n, cmd.flush && sts.can_push,
		req_ready && rsp_valid && rsp.last)

endmodule

### hdl/mctmr_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mctmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/mctmr_ctrl.sv
// controller state machine of the countdown timer bank
// depends on mctmr_pkg
`timescale 1ns / 1ps

module mctmr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mctmr_pkg::sts_t   sts,
	output mctmr_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nxt = sts.req_tick ? ST_SCAN : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_req = 1'b1;
				state_nxt  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_FLUSH;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (sts.can_push) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### hdl/mctmr_dp.sv
// datapath of the countdown timer bank: timer flags, period and count memories,
// scan pipeline and result registers; depends on mctmr_pkg and mctmr_ram
`timescale 1ns / 1ps

module mctmr_dp #(
	parameter int NUM_TIMERS  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mctmr_pkg::req_t  req,
	input  mctmr_pkg::cmd_t  cmd,
	output mctmr_pkg::sts_t  sts,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output mctmr_pkg::rsp_t  rsp
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int AW = $clog2(NUM_TIMERS + 1);
	localparam int EW = mctmr_pkg::EVT_CNT_W;

	mctmr_pkg::req_t req_q;
	logic [AW-1:0]         alloc_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] periodic_q;
	logic [NUM_TIMERS-1:0] notify_q;
	logic [NUM_TIMERS-1:0] per_vld_q;
	logic [NUM_TIMERS-1:0] cnt_vld_q;

	logic [AW-1:0] rd_idx_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [EW-1:0] ev_cnt_q;

	mctmr_pkg::rsp_t hold_q;
	logic            hold_v_q;
	mctmr_pkg::rsp_t out_q;
	logic            out_v_q;

	logic [IW-1:0]          req_idx;
	logic                   req_inb;
	logic [IW-1:0]          scan_idx;
	logic                   scan_more;
	logic [IW-1:0]          use_idx;
	logic [COUNT_WIDTH-1:0] per_in;
	logic [COUNT_WIDTH-1:0] cnt_ram_rd;
	logic [COUNT_WIDTH-1:0] per_ram_rd;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [COUNT_WIDTH-1:0] per_rd;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic                   hit;
	logic                   expire;
	logic                   ev_fire;
	logic                   can_push;
	logic                   stall;
	logic                   step;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   cnt_we;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic                   per_we;
	logic                   op_start;
	logic                   op_resume;
	logic                   op_reset;
	logic [6:0]             evt_ext;
	logic [6:0]             alloc_ext;
	mctmr_pkg::rsp_t        ev_rsp;
	mctmr_pkg::rsp_t        exec_rsp;
	mctmr_pkg::rsp_t        fin_rsp;

	assign req_idx   = IW'(req_q.timer_id);
	assign req_inb   = int'(req_q.timer_id) < NUM_TIMERS;
	assign scan_idx  = rd_idx_q[IW-1:0];
	assign scan_more = rd_idx_q < alloc_q;
	assign use_idx   = cmd.scan ? idx_s1 : req_idx;
	assign per_in    = COUNT_WIDTH'(req_q.period_ticks);
	assign evt_ext   = 7'(idx_s1);
	assign alloc_ext = 7'(alloc_q);

	assign cnt_rd  = cnt_vld_q[use_idx] ? cnt_ram_rd : '0;
	assign per_rd  = per_vld_q[use_idx] ? per_ram_rd : '0;
	assign cnt_dec = cnt_rd - COUNT_WIDTH'(1);

	assign hit     = valid_s1 && running_q[idx_s1];
	assign expire  = hit && (cnt_dec == '0);
	assign ev_fire = expire && notify_q[idx_s1] && (ev_cnt_q < EW'(mctmr_pkg::MAX_RESULTS));

	assign can_push = !out_v_q || rsp_ready;
	assign stall    = cmd.scan && ev_fire && hold_v_q && !can_push;
	assign step     = cmd.scan && !stall;

	assign op_start  = cmd.exec && req_inb && (req_q.mode == mctmr_pkg::MODE_START);
	assign op_resume = cmd.exec && req_inb && (req_q.mode == mctmr_pkg::MODE_RESUME);
	assign op_reset  = cmd.exec && req_inb && (req_q.mode == mctmr_pkg::MODE_RESET);

	assign rd_en   = cmd.rd_req || (step && scan_more);
	assign rd_addr = cmd.rd_req ? req_idx : scan_idx;

	assign per_we = op_start;
	assign cnt_we = (step && hit) || op_start || op_reset;

	always_comb begin
		if (cmd.scan) begin
			cnt_wdata = (expire && periodic_q[idx_s1]) ? per_rd : cnt_dec;
		end else if (op_start) begin
			cnt_wdata = per_in;
		end else begin
			cnt_wdata = per_rd;
		end
	end

	always_comb begin
		ev_rsp             = '0;
		ev_rsp.event_valid = 1'b1;
		ev_rsp.event_timer = evt_ext[4:0];
		exec_rsp           = hold_q;
		if (req_q.mode == mctmr_pkg::MODE_QUERY) begin
			exec_rsp.count_zero = req_inb && (cnt_rd == '0);
			exec_rsp.paused     = !req_inb || !running_q[req_idx];
		end
		if ((req_q.mode == mctmr_pkg::MODE_ALLOC) && (int'(alloc_q) < NUM_TIMERS)) begin
			exec_rsp.new_id   = alloc_ext[4:0];
			exec_rsp.id_valid = 1'b1;
		end
		fin_rsp      = hold_q;
		fin_rsp.last = 1'b1;
	end

	mctmr_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_TIMERS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(use_idx),
		.wdata(cnt_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(cnt_ram_rd)
	);

	mctmr_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_TIMERS)
	) u_per_ram (
		.clk  (clk),
		.we   (per_we),
		.waddr(req_idx),
		.wdata(per_in),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(per_ram_rd)
	);

	// timer flags, valid bits and allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q    <= AW'(1);
			running_q  <= '0;
			periodic_q <= '0;
			notify_q   <= '0;
			per_vld_q  <= '0;
			cnt_vld_q  <= '0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[use_idx] <= 1'b1;
			end
			if (per_we) begin
				per_vld_q[req_idx] <= 1'b1;
			end
			if (step && expire && !periodic_q[idx_s1]) begin
				running_q[idx_s1] <= 1'b0;
			end
			if (op_start) begin
				periodic_q[req_idx] <= req_q.periodic;
				notify_q[req_idx]   <= req_q.notify;
			end
			if (op_start || op_resume || op_reset) begin
				running_q[req_idx] <= 1'b1;
			end
			if (cmd.exec && (req_q.mode == mctmr_pkg::MODE_ALLOC)
				&& (int'(alloc_q) < NUM_TIMERS)) begin
				alloc_q <= alloc_q + AW'(1);
			end
		end
	end

	// scan control, event hold and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			ev_cnt_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.latch) begin
				rd_idx_q <= '0;
				valid_s1 <= 1'b0;
				ev_cnt_q <= '0;
				hold_v_q <= 1'b0;
			end else if (step) begin
				valid_s1 <= scan_more;
				if (scan_more) begin
					rd_idx_q <= rd_idx_q + AW'(1);
					idx_s1   <= scan_idx;
				end
				if (ev_fire) begin
					ev_cnt_q <= ev_cnt_q + EW'(1);
					hold_v_q <= 1'b1;
				end
			end
			if (step && ev_fire && hold_v_q) begin
				out_v_q <= 1'b1;
			end else if (cmd.flush && can_push) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req;
			hold_q <= '0;
		end else if (step && ev_fire) begin
			hold_q <= ev_rsp;
		end else if (cmd.exec) begin
			hold_q <= exec_rsp;
		end
		if (step && ev_fire && hold_v_q) begin
			out_q <= hold_q;
		end else if (cmd.flush && can_push) begin
			out_q <= fin_rsp;
		end
	end

	assign sts.req_tick  = req.mode == mctmr_pkg::MODE_TICK;
	assign sts.scan_done = !valid_s1 && !scan_more;
	assign sts.can_push  = can_push;

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule
